>>> sv/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_IMPLY(lbl, ante, cons, msg)

`define AST_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/srgbqb_pkg.sv
`timescale 1ns / 1ps

package srgbqb_pkg;

    localparam int CodeW = 8;
    localparam int LinW = 16;
    localparam int SumW = LinW + 2;
    localparam int NumCodes = 256;
    localparam int TopCode = NumCodes - 1;
    localparam int ElbowCode = 10;

    typedef logic [CodeW-1:0] code_t;
    typedef logic [LinW-1:0] lin_t;
    typedef lin_t lut_t [NumCodes];

    typedef struct packed {
        code_t top_left_red;
        code_t top_left_green;
        code_t top_left_blue;
        code_t top_right_red;
        code_t top_right_green;
        code_t top_right_blue;
        code_t bottom_left_red;
        code_t bottom_left_green;
        code_t bottom_left_blue;
        code_t bottom_right_red;
        code_t bottom_right_green;
        code_t bottom_right_blue;
    } quad_t;

    typedef struct packed {
        code_t mean_red;
        code_t mean_green;
        code_t mean_blue;
    } pixel_t;

    function automatic real curve_fn(int c);
        real x;
        x = (real'(c) / 255.0 + 0.055) / 1.055;
        return 65536.0 * $pow(x, 2.4);
    endfunction

    function automatic lut_t build_decode();
        lut_t t;
        int v;
        for (int c = 0; c < NumCodes; c++)
        begin
            if (c <= ElbowCode)
                v = (2 * 655360 * c + 32946) / 65892;
            else
                v = $rtoi($floor(curve_fn(c) + 0.5));
            if (v > 65535)
                v = 65535;
            t[c] = lin_t'(v);
        end
        return t;
    endfunction

    // smallest average that reaches each code
    function automatic lut_t build_thresh();
        lut_t t;
        int v;
        for (int c = 0; c < NumCodes; c++)
        begin
            if (c == 0)
                v = 0;
            else if (c <= ElbowCode)
                v = (655360 * c + 32945) / 32946;
            else if (c == TopCode)
                v = 65535;
            else
                v = $rtoi($ceil(curve_fn(c)));
            if (v > 65535)
                v = 65535;
            t[c] = lin_t'(v);
        end
        return t;
    endfunction

    localparam lut_t DECODE_LUT = build_decode();
    localparam lut_t THRESH_LUT = build_thresh();

endpackage

>>> sv/srgbqb_lane.sv
`timescale 1ns / 1ps

module srgbqb_lane (
    input  logic                 clk,
    input  logic                 adv,
    input  srgbqb_pkg::code_t    c0,
    input  srgbqb_pkg::code_t    c1,
    input  srgbqb_pkg::code_t    c2,
    input  srgbqb_pkg::code_t    c3,
    output srgbqb_pkg::code_t    code
);
    import srgbqb_pkg::*;

    logic [SumW-1:0]      sum;
    lin_t                 avg_reg;
    logic [TopCode:1]     therm_reg;
    logic [TopCode:1]     therm_next;
    code_t                code_reg;
    code_t                code_next;
    logic [TopCode:1]     edge_bits;

    assign sum = SumW'(DECODE_LUT[c0]) + SumW'(DECODE_LUT[c1])
               + SumW'(DECODE_LUT[c2]) + SumW'(DECODE_LUT[c3]);

    always_comb
    begin
        for (int c = 1; c <= TopCode; c++)
        begin
            therm_next[c] = (avg_reg >= THRESH_LUT[c]);
        end
    end

    // thermometer to binary via the top set bit
    always_comb
    begin
        code_next = '0;
        for (int c = 1; c <= TopCode; c++)
        begin
            if (c == TopCode)
                edge_bits[c] = therm_reg[c];
            else
                edge_bits[c] = therm_reg[c] & ~therm_reg[c+1];
        end
        for (int c = 1; c <= TopCode; c++)
        begin
            if (edge_bits[c])
                code_next = code_next | code_t'(c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            avg_reg   <= sum[SumW-1:2];
            therm_reg <= therm_next;
            code_reg  <= code_next;
        end
    end

    assign code = code_reg;

endmodule

>>> sv/srgbqb_merge.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module srgbqb_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  srgbqb_pkg::code_t    red,
    input  srgbqb_pkg::code_t    green,
    input  srgbqb_pkg::code_t    blue,
    input  logic                 pixel_stall,
    output logic                 pixel_valid,
    output srgbqb_pkg::pixel_t   pixel,
    output logic                 adv
);
    import srgbqb_pkg::*;

    logic   valid_reg;
    pixel_t pixel_reg;

    assign adv = !valid_reg || !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_reg.mean_red   <= red;
            pixel_reg.mean_green <= green;
            pixel_reg.mean_blue  <= blue;
        end
    end

    assign pixel_valid = valid_reg;
    assign pixel       = pixel_reg;

    `AST_NEXT(a_hold_on_stall, valid_reg && pixel_stall, valid_reg, "output lost while stalled")
    `AST_IMPLY(a_adv_when_empty, !valid_reg, adv, "pipeline frozen with empty output")
    `AST_NEXT(a_load_src, adv && src_valid, valid_reg, "lane result dropped")

endmodule

>>> sv/srgb_quad_box_downsample.sv
`timescale 1ns / 1ps

// gamma-correct 2x2 downsample: each channel of four sRGB8 pixels is decoded to
// 0.16 linear, averaged and re-encoded by threshold search; one quad accepted
// per clock unless stalled, through three lane stages plus the output register;
// the whole pipeline freezes only while a held result is stalled

module srgb_quad_box_downsample (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 quad_valid,
    output logic                 quad_stall,
    input  srgbqb_pkg::quad_t    quad,
    output logic                 pixel_valid,
    input  logic                 pixel_stall,
    output srgbqb_pkg::pixel_t   pixel
);
    import srgbqb_pkg::*;

    logic  adv;
    logic  [2:0] valid_reg;
    code_t red;
    code_t green;
    code_t blue;

    assign quad_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], quad_valid};
    end

    srgbqb_lane u_red (
        .clk  (clk),
        .adv  (adv),
        .c0   (quad.top_left_red),
        .c1   (quad.top_right_red),
        .c2   (quad.bottom_left_red),
        .c3   (quad.bottom_right_red),
        .code (red)
    );

    srgbqb_lane u_green (
        .clk  (clk),
        .adv  (adv),
        .c0   (quad.top_left_green),
        .c1   (quad.top_right_green),
        .c2   (quad.bottom_left_green),
        .c3   (quad.bottom_right_green),
        .code (green)
    );

    srgbqb_lane u_blue (
        .clk  (clk),
        .adv  (adv),
        .c0   (quad.top_left_blue),
        .c1   (quad.top_right_blue),
        .c2   (quad.bottom_left_blue),
        .c3   (quad.bottom_right_blue),
        .code (blue)
    );

    srgbqb_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (valid_reg[2]),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .pixel_stall (pixel_stall),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .adv         (adv)
    );

endmodule

>>> bench/srgb_quad_checker.sv
`timescale 1ns / 1ps

module srgb_quad_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 quad_valid,
    input  logic                 quad_stall,
    input  srgbqb_pkg::quad_t    quad,
    input  logic                 pixel_valid,
    input  logic                 pixel_stall,
    input  srgbqb_pkg::pixel_t   pixel,
    output int                   errors,
    output int                   pending
);
    import srgbqb_pkg::*;

    typedef logic [319:0] big_t;

    lin_t   lin_of_code [NumCodes];
    pixel_t expected_pixels [$];
    big_t   slope_pow;

    initial errors = 0;
    initial pending = 0;

    function automatic big_t raise(big_t b, int n);
        big_t r;
        r = big_t'(1);
        for (int i = 0; i < n; i++)
            r = r * b;
        return r;
    endfunction

    // sign of v^5 * 10761^12 - 2^k * (40c + 561)^12
    function automatic int gamma_sign(int unsigned v, int k, int c);
        big_t l;
        big_t r;
        l = raise(big_t'(v), 5) * slope_pow;
        r = raise(big_t'(40 * c + 561), 12) << k;
        if (l > r)
            return 1;
        if (l < r)
            return -1;
        return 0;
    endfunction

    function automatic lin_t to_linear(int c);
        int lo;
        int hi;
        int mid;
        if (c <= ElbowCode)
            return lin_t'((2 * 655360 * c + 32946) / 65892);
        lo = 1;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (gamma_sign(2 * mid - 1, 85, c) <= 0)
                lo = mid;
            else
                hi = mid - 1;
        end
        return (lo > 65535) ? lin_t'(65535) : lin_t'(lo);
    endfunction

    function automatic bit reaches(int unsigned avg, int c);
        if (c == 0)
            return 1'b1;
        if (c <= ElbowCode)
            return longint'(avg) * 32946 >= longint'(655360) * c;
        return gamma_sign(avg, 80, c) >= 0;
    endfunction

    function automatic code_t to_srgb(int unsigned avg);
        int lo;
        int hi;
        int mid;
        if (avg == 0)
            return code_t'(0);
        if (avg >= 65535)
            return code_t'(TopCode);
        lo = 0;
        hi = TopCode - 1;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (reaches(avg, mid))
                lo = mid;
            else
                hi = mid - 1;
        end
        return code_t'(lo);
    endfunction

    function automatic code_t mean_channel(code_t a, code_t b, code_t c, code_t d);
        int unsigned sum;
        sum = lin_of_code[a] + lin_of_code[b] + lin_of_code[c] + lin_of_code[d];
        return to_srgb(sum >> 2);
    endfunction

    initial
    begin
        slope_pow = raise(big_t'(10761), 12);
        for (int c = 0; c < NumCodes; c++)
            lin_of_code[c] = to_linear(c);
    end

    task automatic report(string field, code_t got, code_t want);
        if (errors < 30)
            $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            if (quad_valid && !quad_stall)
            begin
                want.mean_red = mean_channel(quad.top_left_red, quad.top_right_red,
                    quad.bottom_left_red, quad.bottom_right_red);
                want.mean_green = mean_channel(quad.top_left_green, quad.top_right_green,
                    quad.bottom_left_green, quad.bottom_right_green);
                want.mean_blue = mean_channel(quad.top_left_blue, quad.top_right_blue,
                    quad.bottom_left_blue, quad.bottom_right_blue);
                expected_pixels.push_back(want);
            end
            if (pixel_valid && !pixel_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (errors < 30)
                        $display("unexpected pixel transaction at %0t", $time);
                    errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel.mean_red !== want.mean_red)
                        report("mean_red", pixel.mean_red, want.mean_red);
                    if (pixel.mean_green !== want.mean_green)
                        report("mean_green", pixel.mean_green, want.mean_green);
                    if (pixel.mean_blue !== want.mean_blue)
                        report("mean_blue", pixel.mean_blue, want.mean_blue);
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import srgbqb_pkg::*;

    logic   clk = 0;
    logic   rst_n = 0;
    logic   quad_valid = 0;
    logic   quad_stall;
    quad_t  quad = '0;
    logic   pixel_valid;
    logic   pixel_stall = 0;
    pixel_t pixel;
    int     errors;
    int     pending;

    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_cycles = 0;

    always #10 clk = ~clk;

    srgb_quad_box_downsample dut (
        .clk(clk),
        .rst_n(rst_n),
        .quad_valid(quad_valid),
        .quad_stall(quad_stall),
        .quad(quad),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel)
    );

    srgb_quad_checker u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .quad_valid(quad_valid),
        .quad_stall(quad_stall),
        .quad(quad),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel),
        .errors(errors),
        .pending(pending)
    );

    // receiver stall, with an occasional long hold
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pixel_stall <= 1'b1;
        end
        else
            pixel_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_quad(quad_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            quad_valid <= 1'b0;
            @(posedge clk);
        end
        quad_valid <= 1'b1;
        quad <= q;
        @(posedge clk);
        while (quad_stall)
            @(posedge clk);
    endtask

    function automatic quad_t uniform_quad(code_t v);
        return {12{v}};
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        int kind;
        kind = $urandom_range(9);
        q = {$urandom, $urandom, $urandom};
        if (kind == 0)
            q = uniform_quad(code_t'($urandom));
        else if (kind == 1)
            for (int i = 0; i < 12; i++)
                q[i*8 +: 8] = code_t'($urandom_range(14));
        else if (kind == 2)
            for (int i = 0; i < 12; i++)
                q[i*8 +: 8] = $urandom_range(1) ? code_t'(TopCode) : code_t'($urandom_range(3));
        return q;
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_quad(random_quad());
    endtask

    initial
    begin
        quad_t q;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quad(uniform_quad(code_t'(0)));
        send_quad(uniform_quad(code_t'(TopCode)));
        send_quad(uniform_quad(code_t'(1)));
        send_quad(uniform_quad(code_t'(ElbowCode)));
        send_quad(uniform_quad(code_t'(ElbowCode + 1)));
        send_quad(uniform_quad(code_t'(TopCode - 1)));
        send_quad(uniform_quad(code_t'(128)));
        q = '0;
        q.top_left_red = code_t'(TopCode);
        q.top_right_green = code_t'(TopCode);
        q.bottom_right_blue = code_t'(TopCode);
        send_quad(q);
        q = uniform_quad(code_t'(TopCode));
        q.bottom_left_red = code_t'(0);
        q.bottom_left_green = code_t'(1);
        q.bottom_left_blue = code_t'(ElbowCode);
        send_quad(q);
        send_quad({12{8'hAA}});
        send_quad({12{8'h55}});
        q = '0;
        q.top_left_red = code_t'(1);
        q.top_left_green = code_t'(2);
        q.top_left_blue = code_t'(3);
        send_quad(q);
        for (int i = 0; i < 12; i++)
            q[i*8 +: 8] = code_t'(i * 23);
        send_quad(q);

        run_random(300);

        send_idle_pct = 49;
        run_random(250);

        send_idle_pct = 0;
        recv_stall_pct = 49;
        run_random(250);

        // long receiver hold while sender keeps pushing
        recv_stall_pct = 0;
        hold_cycles = 200;
        run_random(60);

        // sender pause until drained
        quad_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        send_idle_pct = 34;
        recv_stall_pct = 34;
        run_random(300);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_random(240);

        quad_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("srgb_quad_box_downsample test passed");
        else
            $display("srgb_quad_box_downsample test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("srgb_quad_box_downsample test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/srgbqb_pkg.sv
sv/srgbqb_lane.sv
sv/srgbqb_merge.sv
sv/srgb_quad_box_downsample.sv
bench/srgb_quad_checker.sv
bench/tb.sv
